FILE: design/hsfc_pkg.sv
// hsfc_pkg: shared types and constants for the half/single float converter
// no dependencies

package hsfc_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned ResultW = 32;

  // direction codes carried in tuser
  localparam logic KindHalfToSingle = 1'b0;
  localparam logic KindSingleToHalf = 1'b1;

  localparam logic [14:0] HalfInfMag     = 15'h7C00;
  localparam logic [30:0] SingleMaxMag   = 31'h7F7FFFFF;
  localparam logic [7:0]  SingleExpMax   = 8'd255;
  localparam logic [4:0]  HalfExpMax     = 5'd31;
  // single biased exponent window that maps to a normal half (true -14..15)
  localparam logic [7:0]  SingleExpLow   = 8'd113;
  localparam logic [7:0]  SingleExpHigh  = 8'd142;
  localparam logic [7:0]  RebiasHalfToSg = 8'd112;

  typedef struct packed {
    logic                kind;
    logic [ValueW-1:0]   value;
  } hsfc_item_t;

endpackage

FILE: design/half_single_float_convert.sv
// half_single_float_convert: stream top with input and result registers
// depends on hsfc_pkg and hsfc_core

// Converts one beat per cycle between IEEE half and single bit patterns,
// direction chosen by s_axis_tuser (0 half to single, 1 single to half).
// Each beat passes one input register, the conversion logic and one result
// register. Throughput is one beat per cycle while the output side takes
// beats; a stall on the output backs up through both registers. No rounding:
// denormals flush to zero, specials saturate.

module half_single_float_convert
  import hsfc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [ValueW-1:0]  s_axis_tdata,   // value[31:0]
  input  logic               s_axis_tuser,   // kind
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [ResultW-1:0] m_axis_tdata    // result_bits[31:0]
);

  logic               in_vld_q;
  hsfc_item_t         in_q;
  logic               out_vld_q;
  logic [ResultW-1:0] out_q;
  logic [ResultW-1:0] conv;
  logic               out_ready;
  logic               in_ready;

  hsfc_core u_core (
    .item_i   (in_q),
    .result_o (conv)
  );

  assign out_ready     = !out_vld_q || m_axis_tready;
  assign in_ready      = !in_vld_q || out_ready;
  assign s_axis_tready = in_ready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) begin
      in_q <= '{kind: s_axis_tuser, value: s_axis_tdata};
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_ready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && in_vld_q) begin
      out_q <= conv;
    end
  end

  // a half result never sets the upper bits
  a_half_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ready && in_vld_q && in_q.kind == KindSingleToHalf) |=> (out_q[31:16] == 16'd0))
    else $error("half result has upper bits set");

  // a beat in the input stage moves to the result stage when it is free
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_ready) |=> out_vld_q)
    else $error("beat lost between stages");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready) |=> (out_vld_q && $stable(out_q)))
    else $error("stalled result changed");

endmodule

FILE: design/hsfc_core.sv
// hsfc_core: combinational half<->single bit pattern conversion
// depends on hsfc_pkg

module hsfc_core
  import hsfc_pkg::*;
(
  input  hsfc_item_t         item_i,
  output logic [ResultW-1:0] result_o
);

  logic        h_sign;
  logic [4:0]  h_exp;
  logic [9:0]  h_man;
  logic [31:0] h2s;
  logic        s_sign;
  logic [7:0]  s_exp;
  logic [7:0]  s_exp_reb;
  logic [15:0] s2h;

  // half to single
  always_comb begin
    h_sign = item_i.value[15];
    h_exp  = item_i.value[14:10];
    h_man  = item_i.value[9:0];
    if (h_exp == 5'd0) begin
      h2s = {h_sign, 31'd0};
    end else if (h_exp == HalfExpMax) begin
      h2s = {h_sign, SingleMaxMag};
    end else begin
      h2s = {h_sign, ({3'd0, h_exp} + RebiasHalfToSg), h_man, 13'd0};
    end
  end

  // single to half, mantissa truncated
  always_comb begin
    s_sign    = item_i.value[31];
    s_exp     = item_i.value[30:23];
    s_exp_reb = s_exp - RebiasHalfToSg;
    if (s_exp == SingleExpMax || s_exp > SingleExpHigh) begin
      s2h = {s_sign, HalfInfMag};
    end else if (s_exp < SingleExpLow) begin
      s2h = {s_sign, 15'd0};
    end else begin
      s2h = {s_sign, s_exp_reb[4:0], item_i.value[22:13]};
    end
  end

  assign result_o = (item_i.kind == KindSingleToHalf) ? {16'd0, s2h} : h2s;

endmodule

FILE: verif/tb.sv
// tb: self-checking bench for half_single_float_convert, directed and random stimulus with stalls
// depends on hsfc_pkg and the half_single_float_convert rtl

module tb;
  import hsfc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // expected converted patterns, oldest first
  class conv_scoreboard;
    logic [ResultW-1:0] pending_q[$];
    int                 mismatches;

    function logic [ResultW-1:0] convert(logic kind, logic [ValueW-1:0] v);
      logic       sgn;
      logic [4:0] hexp;
      logic [7:0] sexp;
      if (kind == KindHalfToSingle) begin
        sgn  = v[15];
        hexp = v[14:10];
        if (hexp == 5'd0) return {sgn, 31'd0};
        if (hexp == HalfExpMax) return {sgn, SingleMaxMag};
        return {sgn, 8'(hexp + 8'd112), v[9:0], 13'd0};
      end
      sgn  = v[31];
      sexp = v[30:23];
      if (sexp == 8'd0) return {16'd0, sgn, 15'd0};
      if (sexp == SingleExpMax) return {16'd0, sgn, HalfInfMag};
      // true exponent below -14 flushes, above 15 saturates
      if (sexp < 8'd113) return {16'd0, sgn, 15'd0};
      if (sexp > 8'd142) return {16'd0, sgn, HalfInfMag};
      return {16'd0, sgn, 5'(sexp - 8'd112), v[22:13]};
    endfunction

    function void note_input(logic kind, logic [ValueW-1:0] v);
      pending_q.push_back(convert(kind, v));
    endfunction

    function void check_result(logic [ResultW-1:0] got);
      logic [ResultW-1:0] want;
      if (pending_q.size() == 0) begin
        report_mismatch("result beat with nothing pending", got, '0);
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) report_mismatch("result_bits", got, want);
    endfunction

    function void report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %08h want %08h", what, got, want);
      mismatches++;
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [ValueW-1:0]  s_axis_tdata = '0;   // value[31:0]
  logic               s_axis_tuser = 1'b0; // kind
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [ResultW-1:0] m_axis_tdata;        // result_bits[31:0]

  conv_scoreboard sb = new();
  int  send_idle_pct = 27;
  int  recv_idle_pct = 84;
  bit  recv_hold = 1'b0;

  half_single_float_convert dut (.*);

  initial forever #6 clk_i = ~clk_i;

  // receiver side: random stall plus optional long hold-off
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // valid stays high between back-to-back beats, drops only while idling
  task automatic send_beat(logic kind, logic [ValueW-1:0] v);
    bit idle;
    idle = ($urandom_range(99) < send_idle_pct);
    if (idle) s_axis_tvalid <= 1'b0;
    while (idle) begin
      @(posedge clk_i);
      idle = ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= v;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(kind, v);
  endtask

  // random beat biased toward interesting exponents
  task automatic send_random();
    logic [ValueW-1:0] v;
    logic              kind;
    v    = $urandom();
    kind = 1'($urandom_range(1));
    case ($urandom_range(5))
      0: v[30:23] = 8'($urandom_range(110, 145));
      1: v[30:23] = $urandom_range(1) ? 8'd0 : 8'd255;
      2: v[14:10] = $urandom_range(1) ? 5'd0 : 5'd31;
      default: ;
    endcase
    send_beat(kind, v);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [ValueW-1:0] directed[$];
    directed = '{32'h0000_0000, 32'hFFFF_8000, 32'h0000_03FF, 32'h1234_7C00, 32'h0000_FC01,
                 32'h0000_3C00, 32'hABCD_7BFF, 32'h0000_0400};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // half sources: zero, denormal, specials, normals, junk upper bits
    foreach (directed[i]) send_beat(KindHalfToSingle, directed[i]);
    // single sources: zero, denormal, inf, nan, window edges, truncation
    directed = '{32'h0000_0000, 32'h8000_0001, 32'h7F80_0000, 32'hFFC0_0001,
                 32'h3880_0000, 32'h387F_FFFF, 32'h477F_FFFF, 32'hC780_0000,
                 32'h3F80_1FFF, 32'hFFFF_FFFF, 32'h0080_0000};
    foreach (directed[i]) send_beat(KindSingleToHalf, directed[i]);
    wait_drained();
    repeat (300) send_random();
    // long receiver hold-off while sender keeps offering beats
    send_idle_pct = 0;
    fork
      begin
        recv_hold = 1'b1;
        repeat (60) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      repeat (20) send_random();
    join
    send_idle_pct = 84;
    recv_idle_pct = 27;
    repeat (400) send_random();
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (420) send_random();
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("PASS half_single_float_convert");
    end else begin
      $display("FAIL half_single_float_convert");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAIL half_single_float_convert");
    $finish;
  end

endmodule
